[src/pocsp_pkg.sv]
// ----------------------------------------------------------------------------
// pocsp_pkg
// Shared types, codes and keyword tables for the PO catalogue stream parser.
// ----------------------------------------------------------------------------
package pocsp_pkg;

	localparam int CharW = 8;
	localparam int KindW = 3;
	localparam int CodeW = 3;

	// lexer modes
	localparam logic [2:0] LX_IDLE    = 3'd0;
	localparam logic [2:0] LX_COMMENT = 3'd1;
	localparam logic [2:0] LX_ATOM    = 3'd2;
	localparam logic [2:0] LX_STRING  = 3'd3;
	localparam logic [2:0] LX_ESCAPE  = 3'd4;

	// grammar modes
	localparam logic [2:0] GR_WAITID  = 3'd0;
	localparam logic [2:0] GR_ID      = 3'd1;
	localparam logic [2:0] GR_IDMORE  = 3'd2;
	localparam logic [2:0] GR_MSG     = 3'd3;
	localparam logic [2:0] GR_MSGMORE = 3'd4;

	// result kinds
	localparam logic [KindW-1:0] K_IDCHAR  = 3'd0;
	localparam logic [KindW-1:0] K_MSGCHAR = 3'd1;
	localparam logic [KindW-1:0] K_COMMIT  = 3'd2;
	localparam logic [KindW-1:0] K_DONE    = 3'd3;
	localparam logic [KindW-1:0] K_ERROR   = 3'd4;

	// error codes
	localparam logic [CodeW-1:0] E_LEXICAL   = 3'd0;
	localparam logic [CodeW-1:0] E_ID_EXP    = 3'd1;
	localparam logic [CodeW-1:0] E_ID_VAL    = 3'd2;
	localparam logic [CodeW-1:0] E_STR_EXP   = 3'd3;
	localparam logic [CodeW-1:0] E_STR_VAL   = 3'd4;

	// keyword flag bits
	localparam int KF_ID  = 0;
	localparam int KF_STR = 1;

	// result queue depth
	localparam int QDepth = 4;

	typedef struct packed {
		logic [KindW-1:0] kind;
		logic [CharW-1:0] char_out;
		logic [CodeW-1:0] error_code;
		logic             last_of_run;
	} result_t;

	// up to two results from one item
	typedef struct packed {
		logic [1:0] n;
		result_t    r1;
		result_t    r0;
	} pair_t;

	// "msgid", valid for positions 0..4
	function automatic logic [CharW-1:0] kw_id_char(input logic [2:0] p);
		logic [CharW-1:0] c;
		unique case (p)
			3'd0:    c = 8'h6D; // m
			3'd1:    c = 8'h73; // s
			3'd2:    c = 8'h67; // g
			3'd3:    c = 8'h69; // i
			3'd4:    c = 8'h64; // d
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// "msgstr", valid for positions 0..5
	function automatic logic [CharW-1:0] kw_str_char(input logic [2:0] p);
		logic [CharW-1:0] c;
		unique case (p)
			3'd0:    c = 8'h6D; // m
			3'd1:    c = 8'h73; // s
			3'd2:    c = 8'h67; // g
			3'd3:    c = 8'h73; // s
			3'd4:    c = 8'h74; // t
			3'd5:    c = 8'h72; // r
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

[src/pocsp_in_if.sv]
// ----------------------------------------------------------------------------
// pocsp_in_if
// Byte input channel: one catalogue byte or an end marker per item.
// ----------------------------------------------------------------------------
interface pocsp_in_if;
	logic                         valid;
	logic                         ready;
	logic [pocsp_pkg::CharW-1:0]  byte_in;
	logic                         end_of_input;

	modport source(output valid, output byte_in, output end_of_input, input ready);
	modport sink(input valid, input byte_in, input end_of_input, output ready);
endinterface

[src/pocsp_out_if.sv]
// ----------------------------------------------------------------------------
// pocsp_out_if
// Result channel: text characters, commits, done and errors.
// ----------------------------------------------------------------------------
interface pocsp_out_if;
	logic                         valid;
	logic                         ready;
	logic [pocsp_pkg::KindW-1:0]  kind;
	logic [pocsp_pkg::CharW-1:0]  char_out;
	logic [pocsp_pkg::CodeW-1:0]  error_code;
	logic                         last_of_run;

	modport source(output valid, output kind, output char_out, output error_code,
		output last_of_run, input ready);
	modport sink(input valid, input kind, input char_out, input error_code,
		input last_of_run, output ready);
endinterface

[src/po_catalog_stream_parser_top.sv]
// ----------------------------------------------------------------------------
// po_catalog_stream_parser_top
// Streaming lexer and grammar checker for a PO translation catalogue.
// ----------------------------------------------------------------------------
// Use:
//   bytes   : valid/ready sink, one catalogue byte per item, or an end marker
//             (end_of_input high, byte ignored).
//   results : valid/ready source, one result per item: id char, message
//             char, entry commit, done or error (with code). last_of_run
//             marks the final result caused by one input item.
//   An item gives zero, one or two results. An accepted item is held in
//   the input register; the lexer/grammar update runs from there and
//   pushes its results into a four-deep result queue, which offers them
//   on the results channel. Throughput is one item per cycle while each
//   item yields at most one result and the receiver keeps up; the queue
//   absorbs the second result of an item that gives two.
//   The update step fires only while the queue holds two or fewer results,
//   so a stalled receiver fills the queue and then holds off bytes.ready;
//   nothing is dropped.
//   Reset (arst_n low) clears the lexer and grammar state, the input
//   register and the queue. After done or an error every further item is
//   accepted and gives no result until the next reset.
// ----------------------------------------------------------------------------
module po_catalog_stream_parser_top (
	input  logic              clk,
	input  logic              arst_n,
	pocsp_in_if.sink          bytes,
	pocsp_out_if.source       results
);

	localparam int PtrW = $clog2(pocsp_pkg::QDepth);
	localparam int CntW = $clog2(pocsp_pkg::QDepth + 1);
	// fire while at least two free entries remain
	localparam logic [CntW-1:0] FireMax = CntW'(pocsp_pkg::QDepth - 2);

	typedef struct packed {
		logic [2:0]        gr;
		logic              fin;
		pocsp_pkg::pair_t  pr;
	} atom_res_t;

	// ---------------------------------------------------------------- helpers
	function automatic pocsp_pkg::pair_t push(
		input pocsp_pkg::pair_t             p,
		input logic [pocsp_pkg::KindW-1:0]  k,
		input logic [pocsp_pkg::CharW-1:0]  ch,
		input logic [pocsp_pkg::CodeW-1:0]  code
	);
		pocsp_pkg::pair_t o;
		pocsp_pkg::result_t r;
		o = p;
		r.kind        = k;
		r.char_out    = ch;
		r.error_code  = code;
		r.last_of_run = 1'b0;
		if (p.n == 2'd0) begin
			o.r0 = r;
			o.n  = 2'd1;
		end else if (p.n == 2'd1) begin
			o.r1 = r;
			o.n  = 2'd2;
		end
		return o;
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	// keyword decision at the end of an atom
	function automatic atom_res_t atom_done(
		input logic [2:0]        gr,
		input logic [1:0]        kmf,
		input logic [2:0]        pos,
		input pocsp_pkg::pair_t  pr
	);
		atom_res_t a;
		logic is_id;
		logic is_str;
		a.gr  = gr;
		a.fin = 1'b0;
		a.pr  = pr;
		is_id  = kmf[pocsp_pkg::KF_ID] && (pos == 3'd5);
		is_str = kmf[pocsp_pkg::KF_STR] && (pos == 3'd6);
		unique case (gr)
			pocsp_pkg::GR_ID: begin
				a.pr  = push(a.pr, pocsp_pkg::K_ERROR, '0, pocsp_pkg::E_ID_VAL);
				a.fin = 1'b1;
			end
			pocsp_pkg::GR_IDMORE: begin
				if (is_str) begin
					a.gr = pocsp_pkg::GR_MSG;
				end else begin
					a.pr  = push(a.pr, pocsp_pkg::K_ERROR, '0, pocsp_pkg::E_STR_EXP);
					a.fin = 1'b1;
				end
			end
			pocsp_pkg::GR_MSG, pocsp_pkg::GR_MSGMORE: begin
				a.pr = push(a.pr, pocsp_pkg::K_COMMIT, '0, '0);
				if (is_id) begin
					a.gr = pocsp_pkg::GR_ID;
				end else begin
					a.pr  = push(a.pr, pocsp_pkg::K_ERROR, '0, pocsp_pkg::E_ID_EXP);
					a.fin = 1'b1;
				end
			end
			default: begin
				if (is_id) begin
					a.gr = pocsp_pkg::GR_ID;
				end else begin
					a.pr  = push(a.pr, pocsp_pkg::K_ERROR, '0, pocsp_pkg::E_ID_EXP);
					a.fin = 1'b1;
				end
			end
		endcase
		return a;
	endfunction

	// text character, tagged by the part of the entry it belongs to
	function automatic pocsp_pkg::pair_t text_char(
		input logic [2:0]        gr,
		input logic [7:0]        c,
		input pocsp_pkg::pair_t  pr
	);
		pocsp_pkg::pair_t o;
		o = pr;
		if (gr == pocsp_pkg::GR_ID || gr == pocsp_pkg::GR_IDMORE) begin
			o = push(pr, pocsp_pkg::K_IDCHAR, c, '0);
		end else if (gr == pocsp_pkg::GR_MSG || gr == pocsp_pkg::GR_MSGMORE) begin
			o = push(pr, pocsp_pkg::K_MSGCHAR, c, '0);
		end
		return o;
	endfunction

	// ---------------------------------------------------------------- state
	logic [2:0] lex_q;
	logic [2:0] gram_q;
	logic [2:0] pos_q;
	logic [1:0] kmf_q;
	logic       fin_q;

	// input register
	logic                          valid_s1;
	logic [pocsp_pkg::CharW-1:0]   byte_s1;
	logic                          eoi_s1;

	// result queue
	pocsp_pkg::result_t     mem_q [pocsp_pkg::QDepth];
	logic [PtrW-1:0]        wr_ptr_q;
	logic [PtrW-1:0]        rd_ptr_q;
	logic [CntW-1:0]        cnt_q;

	logic fire;
	logic in_acc;
	logic pop;

	assign fire    = valid_s1 && (cnt_q <= FireMax);
	assign in_acc  = bytes.valid && bytes.ready;
	assign pop     = results.valid && results.ready;

	assign bytes.ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			byte_s1 <= bytes.byte_in;
			eoi_s1  <= bytes.end_of_input;
		end
	end

	// ---------------------------------------------------------------- step
	logic [2:0]        lx_n;
	logic [2:0]        gr_n;
	logic [2:0]        pos_n;
	logic [1:0]        kmf_n;
	logic              fin_n;
	pocsp_pkg::pair_t  pr_n;

	always_comb begin
		atom_res_t a;
		logic      do_end;
		logic [7:0] c;
		lx_n   = lex_q;
		gr_n   = gram_q;
		pos_n  = pos_q;
		kmf_n  = kmf_q;
		fin_n  = fin_q;
		pr_n   = '0;
		a      = '0;
		do_end = 1'b0;
		c      = byte_s1;

		if (!fin_q) begin
			if (eoi_s1) begin
				unique case (lex_q)
					pocsp_pkg::LX_ATOM: begin
						a      = atom_done(gr_n, kmf_n, pos_n, pr_n);
						gr_n   = a.gr;
						fin_n  = a.fin;
						pr_n   = a.pr;
						do_end = !a.fin;
					end
					pocsp_pkg::LX_STRING, pocsp_pkg::LX_ESCAPE: begin
						pr_n  = push(pr_n, pocsp_pkg::K_ERROR, '0, pocsp_pkg::E_LEXICAL);
						fin_n = 1'b1;
					end
					default: do_end = 1'b1;
				endcase
				if (do_end) begin
					if (gr_n == pocsp_pkg::GR_MSG) begin
						pr_n = push(pr_n, pocsp_pkg::K_ERROR, '0, pocsp_pkg::E_STR_VAL);
					end else begin
						if (gr_n == pocsp_pkg::GR_MSGMORE)
							pr_n = push(pr_n, pocsp_pkg::K_COMMIT, '0, '0);
						pr_n = push(pr_n, pocsp_pkg::K_DONE, '0, '0);
					end
					fin_n = 1'b1;
				end
			end else begin
				unique case (lex_q)
					pocsp_pkg::LX_COMMENT: begin
						if (c == 8'h0A)
							lx_n = pocsp_pkg::LX_IDLE;
					end
					pocsp_pkg::LX_ATOM: begin
						if (is_space(c)) begin
							lx_n  = pocsp_pkg::LX_IDLE;
							a     = atom_done(gr_n, kmf_n, pos_n, pr_n);
							gr_n  = a.gr;
							fin_n = a.fin;
							pr_n  = a.pr;
						end else if (is_alpha(c) || is_digit(c)) begin
							if (pos_q >= 3'd5 || pocsp_pkg::kw_id_char(pos_q) != c)
								kmf_n[pocsp_pkg::KF_ID] = 1'b0;
							if (pos_q >= 3'd6 || pocsp_pkg::kw_str_char(pos_q) != c)
								kmf_n[pocsp_pkg::KF_STR] = 1'b0;
							if (pos_q != 3'd7)
								pos_n = pos_q + 3'd1;
						end else begin
							pr_n  = push(pr_n, pocsp_pkg::K_ERROR, '0, pocsp_pkg::E_LEXICAL);
							fin_n = 1'b1;
						end
					end
					pocsp_pkg::LX_STRING: begin
						if (c == 8'h22) begin
							lx_n = pocsp_pkg::LX_IDLE;
							// closing quote: string belongs to msgid or msgstr, else an id was expected
							if (gram_q == pocsp_pkg::GR_ID || gram_q == pocsp_pkg::GR_IDMORE) begin
								gr_n = pocsp_pkg::GR_IDMORE;
							end else if (gram_q == pocsp_pkg::GR_MSG ||
								gram_q == pocsp_pkg::GR_MSGMORE) begin
								gr_n = pocsp_pkg::GR_MSGMORE;
							end else begin
								pr_n  = push(pr_n, pocsp_pkg::K_ERROR, '0, pocsp_pkg::E_ID_EXP);
								fin_n = 1'b1;
							end
						end else if (c == 8'h5C) begin
							lx_n = pocsp_pkg::LX_ESCAPE;
						end else if (c < 8'd32) begin
							pr_n  = push(pr_n, pocsp_pkg::K_ERROR, '0, pocsp_pkg::E_LEXICAL);
							fin_n = 1'b1;
						end else begin
							pr_n = text_char(gram_q, c, pr_n);
						end
					end
					pocsp_pkg::LX_ESCAPE: begin
						if (c < 8'd32) begin
							pr_n  = push(pr_n, pocsp_pkg::K_ERROR, '0, pocsp_pkg::E_LEXICAL);
							fin_n = 1'b1;
						end else begin
							// backslash-n is a newline, any other escape is literal
							pr_n = text_char(gram_q, (c == 8'h6E) ? 8'h0A : c, pr_n);
							lx_n = pocsp_pkg::LX_STRING;
						end
					end
					default: begin
						if (is_space(c) || c < 8'd32) begin
							lx_n = lex_q;
						end else if (c == 8'h23) begin
							lx_n = pocsp_pkg::LX_COMMENT;
						end else if (c == 8'h22) begin
							lx_n = pocsp_pkg::LX_STRING;
						end else if (is_alpha(c)) begin
							lx_n  = pocsp_pkg::LX_ATOM;
							pos_n = 3'd1;
							kmf_n[pocsp_pkg::KF_ID]  = (pocsp_pkg::kw_id_char(3'd0) == c);
							kmf_n[pocsp_pkg::KF_STR] = (pocsp_pkg::kw_str_char(3'd0) == c);
						end else begin
							pr_n  = push(pr_n, pocsp_pkg::K_ERROR, '0, pocsp_pkg::E_LEXICAL);
							fin_n = 1'b1;
						end
					end
				endcase
			end
		end

		// mark the final result of this item
		if (pr_n.n == 2'd1)
			pr_n.r0.last_of_run = 1'b1;
		else if (pr_n.n == 2'd2)
			pr_n.r1.last_of_run = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lex_q  <= pocsp_pkg::LX_IDLE;
			gram_q <= pocsp_pkg::GR_WAITID;
			pos_q  <= 3'd0;
			kmf_q  <= 2'b11;
			fin_q  <= 1'b0;
		end else if (fire) begin
			lex_q  <= lx_n;
			gram_q <= gr_n;
			pos_q  <= pos_n;
			kmf_q  <= kmf_n;
			fin_q  <= fin_n;
		end
	end

	// ---------------------------------------------------------------- queue
	logic [1:0] push_n;
	assign push_n = fire ? pr_n.n : 2'd0;

	always_ff @(posedge clk) begin
		if (push_n != 2'd0)
			mem_q[wr_ptr_q] <= pr_n.r0;
		if (push_n == 2'd2)
			mem_q[wr_ptr_q + PtrW'(1)] <= pr_n.r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PtrW'(push_n);
			if (pop)
				rd_ptr_q <= rd_ptr_q + PtrW'(1);
			cnt_q <= cnt_q + CntW'(push_n) - CntW'(pop);
		end
	end

	assign results.valid       = (cnt_q != '0);
	assign results.kind        = mem_q[rd_ptr_q].kind;
	assign results.char_out    = mem_q[rd_ptr_q].char_out;
	assign results.error_code  = mem_q[rd_ptr_q].error_code;
	assign results.last_of_run = mem_q[rd_ptr_q].last_of_run;

endmodule

[bench/po_catalog_stream_parser_top_test.sv]
// ----------------------------------------------------------------------------
// po_catalog_stream_parser_top_test
// Self-checking bench for the PO catalogue stream parser. Bytes of
// well-formed catalogue entries, with random text, escapes, comments and
// filler, are fed through the byte channel under random bursts and gaps.
// A behavioural parser inside the bench predicts every id char, message
// char, commit, done and error. Each item on the result channel is checked
// against the oldest prediction. The run ends with one randomly chosen way
// of finishing or failing, followed by items that must be ignored.
// ----------------------------------------------------------------------------
module po_catalog_stream_parser_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	// run sizing
	localparam int ItemTarget  = 1850;
	localparam int HoldCycles  = 300;   // long receiver stall for the pressure test
	localparam int DrainCycles = 24;    // quiet time after the last prediction is met
	localparam int CycleLimit  = 250000;

	// keywords, and bytes that break a token
	localparam string KW_ID    = "msgid";
	localparam string KW_STR   = "msgstr";
	localparam string IDLE_BAD = "!$%&'()*+,-./0123456789:;<=>?@[\\]^_`{|}~";
	localparam string ATOM_BAD = "!$%&'()*+,-./:;<=>?@[\\]^_`{|}~\"#";

	logic clk;
	logic arst_n;

	pocsp_in_if  byte_ch ();
	pocsp_out_if result_ch ();

	po_catalog_stream_parser_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.bytes   (byte_ch),
		.results (result_ch)
	);

	// ------------------------------------------------------------------
	// Parser shadow state
	// ------------------------------------------------------------------
	logic [2:0] lex_st;
	logic [2:0] gram_st;
	logic [2:0] atom_len;
	logic [1:0] kw_live;
	bit         run_over;

	// results produced by the item in hand (two at most)
	pocsp_pkg::result_t step_res [2];
	int                 step_n;

	// predicted results not yet seen on the result channel
	pocsp_pkg::result_t predicted_tokens [$];

	int  mismatch_count;
	int  bytes_fed;
	int  burst_left;
	bit  steady_send;   // sender offers back to back, no gaps
	bit  hold_req;      // asks the receiver for one long stall
	int  cycle_count;

	logic [7:0] ws_set [6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};

	function automatic bit is_ws(logic [7:0] c);
		return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	function automatic bit is_letter(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic bit is_alnum(logic [7:0] c);
		return is_letter(c) || (c >= "0" && c <= "9");
	endfunction

	function automatic void add_result(logic [pocsp_pkg::KindW-1:0] k,
			logic [pocsp_pkg::CharW-1:0] ch, logic [pocsp_pkg::CodeW-1:0] code);
		if (step_n < 2) begin
			step_res[step_n] = '{kind: k, char_out: ch, error_code: code, last_of_run: 1'b0};
			step_n++;
		end
	endfunction

	function automatic void abort_run(logic [pocsp_pkg::CodeW-1:0] code);
		add_result(pocsp_pkg::K_ERROR, '0, code);
		run_over = 1'b1;
	endfunction

	// one more letter or digit of an atom; keyword flags drop on first miss
	function automatic void take_letter(logic [7:0] c);
		if (atom_len >= 3'd5 || KW_ID[atom_len] != c)
			kw_live[pocsp_pkg::KF_ID] = 1'b0;
		if (atom_len >= 3'd6 || KW_STR[atom_len] != c)
			kw_live[pocsp_pkg::KF_STR] = 1'b0;
		if (atom_len < 3'd7)
			atom_len++;
	endfunction

	function automatic void atom_done();
		bit is_id;
		bit is_str;
		is_id  = kw_live[pocsp_pkg::KF_ID] && atom_len == 3'd5;
		is_str = kw_live[pocsp_pkg::KF_STR] && atom_len == 3'd6;
		case (gram_st)
			pocsp_pkg::GR_ID: begin
				abort_run(pocsp_pkg::E_ID_VAL);
			end
			pocsp_pkg::GR_IDMORE: begin
				if (is_str)
					gram_st = pocsp_pkg::GR_MSG;
				else
					abort_run(pocsp_pkg::E_STR_EXP);
			end
			pocsp_pkg::GR_MSG, pocsp_pkg::GR_MSGMORE: begin
				// entry closes even when the message has no strings
				add_result(pocsp_pkg::K_COMMIT, '0, '0);
				if (is_id)
					gram_st = pocsp_pkg::GR_ID;
				else
					abort_run(pocsp_pkg::E_ID_EXP);
			end
			default: begin
				if (is_id)
					gram_st = pocsp_pkg::GR_ID;
				else
					abort_run(pocsp_pkg::E_ID_EXP);
			end
		endcase
	endfunction

	function automatic void string_done();
		case (gram_st)
			pocsp_pkg::GR_ID, pocsp_pkg::GR_IDMORE:   gram_st = pocsp_pkg::GR_IDMORE;
			pocsp_pkg::GR_MSG, pocsp_pkg::GR_MSGMORE: gram_st = pocsp_pkg::GR_MSGMORE;
			default:                                  abort_run(pocsp_pkg::E_ID_EXP);
		endcase
	endfunction

	function automatic void input_done();
		if (gram_st == pocsp_pkg::GR_MSG) begin
			abort_run(pocsp_pkg::E_STR_VAL);
		end else begin
			if (gram_st == pocsp_pkg::GR_MSGMORE)
				add_result(pocsp_pkg::K_COMMIT, '0, '0);
			add_result(pocsp_pkg::K_DONE, '0, '0);
			run_over = 1'b1;
		end
	endfunction

	// text outside msgid/msgstr values is swallowed silently
	function automatic void text_out(logic [7:0] c);
		if (gram_st == pocsp_pkg::GR_ID || gram_st == pocsp_pkg::GR_IDMORE)
			add_result(pocsp_pkg::K_IDCHAR, c, '0);
		else if (gram_st == pocsp_pkg::GR_MSG || gram_st == pocsp_pkg::GR_MSGMORE)
			add_result(pocsp_pkg::K_MSGCHAR, c, '0);
	endfunction

	// Predict the results of one accepted item and queue them
	task automatic lex_and_parse(input logic [7:0] c, input logic eoi);
		step_n = 0;
		if (run_over)
			return;
		if (eoi) begin
			case (lex_st)
				pocsp_pkg::LX_ATOM: begin
					// pending atom is settled before the end is seen
					atom_done();
					if (!run_over)
						input_done();
				end
				pocsp_pkg::LX_STRING, pocsp_pkg::LX_ESCAPE: abort_run(pocsp_pkg::E_LEXICAL);
				default:                                    input_done();
			endcase
		end else begin
			case (lex_st)
				pocsp_pkg::LX_COMMENT: begin
					if (c == 8'h0A)
						lex_st = pocsp_pkg::LX_IDLE;
				end
				pocsp_pkg::LX_ATOM: begin
					if (is_ws(c)) begin
						lex_st = pocsp_pkg::LX_IDLE;
						atom_done();
					end else if (is_alnum(c)) begin
						take_letter(c);
					end else begin
						abort_run(pocsp_pkg::E_LEXICAL);
					end
				end
				pocsp_pkg::LX_STRING: begin
					if (c == "\"") begin
						lex_st = pocsp_pkg::LX_IDLE;
						string_done();
					end else if (c == "\\") begin
						lex_st = pocsp_pkg::LX_ESCAPE;
					end else if (c < 8'h20) begin
						abort_run(pocsp_pkg::E_LEXICAL);
					end else begin
						text_out(c);
					end
				end
				pocsp_pkg::LX_ESCAPE: begin
					if (c < 8'h20) begin
						abort_run(pocsp_pkg::E_LEXICAL);
					end else begin
						text_out(c == "n" ? 8'h0A : c);
						lex_st = pocsp_pkg::LX_STRING;
					end
				end
				default: begin
					if (is_ws(c) || c < 8'h20) begin
						// filler between tokens
					end else if (c == "#") begin
						lex_st = pocsp_pkg::LX_COMMENT;
					end else if (c == "\"") begin
						lex_st = pocsp_pkg::LX_STRING;
					end else if (is_letter(c)) begin
						lex_st   = pocsp_pkg::LX_ATOM;
						atom_len = '0;
						kw_live  = 2'b11;
						take_letter(c);
					end else begin
						abort_run(pocsp_pkg::E_LEXICAL);
					end
				end
			endcase
		end
		if (step_n > 0)
			step_res[step_n-1].last_of_run = 1'b1;
		for (int i = 0; i < step_n; i++)
			predicted_tokens.push_back(step_res[i]);
	endtask

	// ------------------------------------------------------------------
	// Clock, cycle limit
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count <= CycleLimit) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("TEST FAILED");
		$finish;
	end

	// ------------------------------------------------------------------
	// Sender: one item per call, bursts of random length, random gaps
	// ------------------------------------------------------------------
	task automatic send_byte(input logic [7:0] b, input logic eoi);
		int gap;
		if (burst_left == 0) begin
			gap = steady_send ? 0 : ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 7));
			if (gap > 0) begin
				byte_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		byte_ch.valid        <= 1'b1;
		byte_ch.byte_in      <= b;
		byte_ch.end_of_input <= eoi;
		@(posedge clk);
		while (!byte_ch.ready)
			@(posedge clk);
		lex_and_parse(b, eoi);
		burst_left--;
		bytes_fed++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], 1'b0);
	endtask

	task automatic send_end();
		send_byte(8'($urandom_range(0, 255)), 1'b1);
	endtask

	// whitespace first (it closes an atom), then control filler, maybe a comment
	task automatic send_sep();
		logic [7:0] b;
		send_byte(ws_set[$urandom_range(0, 5)], 1'b0);
		repeat ($urandom_range(0, 2))
			send_byte(8'($urandom_range(0, 32)), 1'b0);
		if ($urandom_range(0, 7) == 0) begin
			send_byte("#", 1'b0);
			repeat ($urandom_range(0, 8)) begin
				b = 8'($urandom_range(0, 255));
				if (b == 8'h0A)
					b = 8'h0B;
				send_byte(b, 1'b0);
			end
			send_byte(8'h0A, 1'b0);
		end
	endtask

	// quoted string: printable text, high bytes and escapes
	task automatic send_string();
		logic [7:0] b;
		send_byte("\"", 1'b0);
		repeat ($urandom_range(0, 10)) begin
			case ($urandom_range(0, 9))
				0: begin
					send_byte("\\", 1'b0);
					b = $urandom_range(0, 1) ? 8'(KW_ID[4] + 8'h0A) : 8'($urandom_range(32, 255));
					send_byte(b, 1'b0);
				end
				1: send_byte(8'($urandom_range(128, 255)), 1'b0);
				default: begin
					do
						b = 8'($urandom_range(32, 126));
					while (b == "\"" || b == "\\");
					send_byte(b, 1'b0);
				end
			endcase
		end
		send_byte("\"", 1'b0);
	endtask

	// one catalogue entry; the msgid keyword may already have been sent
	task automatic send_entry(input bit with_id);
		if (with_id) begin
			send_text("msgid");
			send_sep();
		end
		repeat ($urandom_range(1, 3)) begin
			send_string();
			if ($urandom_range(0, 1))
				send_sep();
		end
		send_text("msgstr");
		send_sep();
		// now and then a message with no strings: committed by the next msgid
		if ($urandom_range(0, 9) != 0) begin
			repeat ($urandom_range(1, 3)) begin
				send_string();
				if ($urandom_range(0, 1))
					send_sep();
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Receiver: own stall pattern, plus one long hold on request
	// ------------------------------------------------------------------
	initial begin : receiver
		int mode;
		int left;
		int hold;
		result_ch.ready = 1'b0;
		mode = 0;
		left = 0;
		hold = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold     = HoldCycles;
			end
			if (hold > 0) begin
				hold--;
				result_ch.ready <= 1'b0;
			end else begin
				if (left == 0) begin
					mode = $urandom_range(0, 3);
					left = $urandom_range(10, 150);
				end
				left--;
				case (mode)
					0: result_ch.ready <= 1'b1;
					1: result_ch.ready <= 1'($urandom_range(0, 1));
					2: result_ch.ready <= ($urandom_range(0, 3) == 0);
					default: result_ch.ready <= (left % 5 != 0);
				endcase
			end
		end
	end

	// ------------------------------------------------------------------
	// Result checking against the oldest prediction
	// ------------------------------------------------------------------
	function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
		if (want !== got) begin
			$display("%0t ns: %s mismatch, expected %0h actual %0h", $time, name, want, got);
			mismatch_count++;
		end
	endfunction

	always @(posedge clk) begin : result_checker
		pocsp_pkg::result_t want;
		if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
			if (predicted_tokens.size() == 0) begin
				$display("%0t ns: unexpected result, expected none actual kind %0h char %0h code %0h",
					$time, result_ch.kind, result_ch.char_out, result_ch.error_code);
				mismatch_count++;
			end else begin
				want = predicted_tokens.pop_front();
				check_field("kind", 8'(want.kind), 8'(result_ch.kind));
				check_field("char_out", want.char_out, result_ch.char_out);
				check_field("error_code", 8'(want.error_code), 8'(result_ch.error_code));
				check_field("last_of_run", 8'(want.last_of_run), 8'(result_ch.last_of_run));
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Hand-written opening: comment with a high byte, control filler,
	// an escape and a high byte in the id, an empty message committed by the next msgid.
	task automatic test_directed_catalogue();
		send_text("#");
		send_byte(8'hFF, 1'b0);
		send_byte(8'h0A, 1'b0);
		send_byte(8'h01, 1'b0);
		send_text("msgid");
		send_byte(8'h09, 1'b0);
		send_text("\"\\n");
		send_byte(8'hFF, 1'b0);
		send_text(" \"msgstr");
		send_byte(8'h0C, 1'b0);
		send_text("msgid ");
	endtask

	// Well-formed entries with random content up to a byte count
	task automatic test_random_entries(input int upto, input bit id_pending);
		bit with_id;
		with_id = !id_pending;
		while (bytes_fed < upto) begin
			send_entry(with_id);
			with_id = 1'b1;
		end
	endtask

	// Receiver stalls for a long stretch while bytes keep coming, so the
	// result queue fills and the byte channel must hold off.
	task automatic test_input_backpressure();
		steady_send = 1'b1;
		burst_left  = 0;
		hold_req    = 1'b1;
		send_entry(1'b1);
		send_entry(1'b1);
		steady_send = 1'b0;
	endtask

	// One way of ending the run, chosen at random: clean end, end in
	// various tokens, grammar errors and lexical errors.
	task automatic test_run_termination();
		case ($urandom_range(0, 14))
			0: begin
				if ($urandom_range(0, 1))
					send_text("# tail");
				send_end();
			end
			1: begin
				send_text("msgid");
				send_end();
			end
			2: begin
				send_text("msgid \"ab");
				send_end();
			end
			3: begin
				send_text("msgid \"a\\");
				send_end();
			end
			4: begin
				send_text("msgid ");
				send_string();
				send_end();
			end
			5: begin
				send_text("msgid ");
				send_end();
			end
			6: send_text("msgstr ");
			7: send_text("msgid msgid ");
			8: begin
				send_text("msgid ");
				send_string();
				send_text("msgidx ");
			end
			9: begin
				send_text("msgid ");
				send_string();
				send_text("msgstr");
				send_end();
			end
			10: begin
				send_text("msgid ");
				send_string();
				send_text("msgstr ");
				send_end();
			end
			11: begin
				if ($urandom_range(0, 1))
					send_byte(IDLE_BAD[$urandom_range(0, IDLE_BAD.len() - 1)], 1'b0);
				else
					send_byte(8'($urandom_range(128, 255)), 1'b0);
			end
			12: begin
				send_text("msg");
				case ($urandom_range(0, 2))
					0: send_byte(ATOM_BAD[$urandom_range(0, ATOM_BAD.len() - 1)], 1'b0);
					1: send_byte(8'($urandom_range(128, 255)), 1'b0);
					default: send_byte(8'($urandom_range(14, 31)), 1'b0);
				endcase
			end
			13: begin
				send_text("msgid \"a");
				if ($urandom_range(0, 1))
					send_text("\\");
				send_byte(8'($urandom_range(0, 31)), 1'b0);
			end
			default: send_text("msgstrxyz ");
		endcase
	endtask

	// Once finished, anything fed in must give nothing back
	task automatic test_ignored_after_end();
		repeat (40)
			send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n               = 1'b0;
		byte_ch.valid        = 1'b0;
		byte_ch.byte_in      = '0;
		byte_ch.end_of_input = 1'b0;
		lex_st               = pocsp_pkg::LX_IDLE;
		gram_st              = pocsp_pkg::GR_WAITID;
		atom_len             = '0;
		kw_live              = 2'b11;
		run_over             = 1'b0;
		mismatch_count       = 0;
		bytes_fed            = 0;
		burst_left           = 0;
		steady_send          = 1'b0;
		hold_req             = 1'b0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		test_directed_catalogue();
		test_random_entries(ItemTarget / 2, 1'b1);
		test_input_backpressure();
		test_random_entries(ItemTarget, 1'b0);
		test_run_termination();
		test_ignored_after_end();

		byte_ch.valid <= 1'b0;
		while (predicted_tokens.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);

		if (mismatch_count == 0 && predicted_tokens.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
